// ===== src/q15c_pkg.sv =====
`timescale 1ns / 1ps
// q15c_pkg: shared types, widths and codes for the Q15 convolution core.
// No dependencies; imported by every module of the core except q15c_ram.
package q15c_pkg;

    localparam int IMAGE_DEPTH_DEF  = 2048;
    localparam int WEIGHT_DEPTH_DEF = 256;
    localparam int MAX_KERNELS_DEF  = 4;

    localparam int QSHIFT      = 15;
    localparam int DATA_W      = 16;
    localparam int OPC_W       = 2;
    localparam int STORE_IDX_W = 11;
    localparam int OC_W        = 2;
    localparam int COORD_W     = 6;
    localparam int ROWS_W      = 7;
    localparam int CH_W        = 4;
    localparam int KCNT_W      = 3;

    localparam int IA_W     = 19;  // image address, wide enough for any register values
    localparam int WA_W     = 14;  // weight address
    localparam int PLANE_W  = 14;
    localparam int KSZ_W    = 12;
    localparam int MA_W     = 12;
    localparam int MB_W     = 7;
    localparam int PROD_W   = MA_W + MB_W;

    localparam int S_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int PC_W       = 4;

    typedef enum logic [OPC_W-1:0] {
        OPC_LOAD_IMG  = 2'd0,
        OPC_LOAD_WGT  = 2'd1,
        OPC_LOAD_BIAS = 2'd2,
        OPC_COMPUTE   = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_ROWS      = 3'd0,
        CFG_IN_COLS      = 3'd1,
        CFG_IN_CHANNELS  = 3'd2,
        CFG_KERNEL_ROWS  = 3'd3,
        CFG_KERNEL_COLS  = 3'd4,
        CFG_KERNEL_COUNT = 3'd5
    } t_cfg_idx;

    // datapath operations, one per microcode step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ROW,
        OP_PLANE,
        OP_KSZ0,
        OP_KSZ1,
        OP_KBASE,
        OP_INIT,
        OP_MAC,
        OP_EMIT_OK,
        OP_EMIT_ERR
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_NO_COMPUTE,
        C_RANGE,
        C_EMPTY,
        C_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] jump;
        logic [PC_W-1:0] nxt;
        logic            rdy;
    } t_ctrl;

    typedef struct packed {
        logic acc_compute;
        logic range_err;
        logic empty;
        logic more;
        logic out_busy;
    } t_stat;

endpackage

// ===== src/q15c_ram.sv =====
`timescale 1ns / 1ps
// q15c_ram: generic simple dual-port RAM, one write port, registered read.
// No dependencies.
module q15c_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/q15c_seq.sv =====
`timescale 1ns / 1ps
// q15c_seq: microcode sequencer; step counter, program ROM and jump logic.
// Depends on q15c_pkg.
module q15c_seq
    import q15c_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
    localparam logic [PC_W-1:0] PC_PLANE = 4'd2;
    localparam logic [PC_W-1:0] PC_KSZ0  = 4'd3;
    localparam logic [PC_W-1:0] PC_KSZ1  = 4'd4;
    localparam logic [PC_W-1:0] PC_KBASE = 4'd5;
    localparam logic [PC_W-1:0] PC_INIT  = 4'd6;
    localparam logic [PC_W-1:0] PC_MAC   = 4'd7;
    localparam logic [PC_W-1:0] PC_DRN0  = 4'd8;
    localparam logic [PC_W-1:0] PC_DRN1  = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd10;
    localparam logic [PC_W-1:0] PC_ERR   = 4'd11;

    function automatic t_ctrl f_rom(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NONE, cond: C_NONE, jump: PC_IDLE, nxt: PC_IDLE, rdy: 1'b0};
        unique case (pc)
            PC_IDLE:  w = '{OP_NONE,     C_NO_COMPUTE, PC_IDLE,  PC_CHECK, 1'b1};
            PC_CHECK: w = '{OP_ROW,      C_RANGE,      PC_ERR,   PC_PLANE, 1'b0};
            PC_PLANE: w = '{OP_PLANE,    C_NONE,       PC_IDLE,  PC_KSZ0,  1'b0};
            PC_KSZ0:  w = '{OP_KSZ0,     C_NONE,       PC_IDLE,  PC_KSZ1,  1'b0};
            PC_KSZ1:  w = '{OP_KSZ1,     C_NONE,       PC_IDLE,  PC_KBASE, 1'b0};
            PC_KBASE: w = '{OP_KBASE,    C_NONE,       PC_IDLE,  PC_INIT,  1'b0};
            PC_INIT:  w = '{OP_INIT,     C_EMPTY,      PC_EMIT,  PC_MAC,   1'b0};
            PC_MAC:   w = '{OP_MAC,      C_MORE,       PC_MAC,   PC_DRN0,  1'b0};
            PC_DRN0:  w = '{OP_NONE,     C_NONE,       PC_IDLE,  PC_DRN1,  1'b0};
            PC_DRN1:  w = '{OP_NONE,     C_NONE,       PC_IDLE,  PC_EMIT,  1'b0};
            PC_EMIT:  w = '{OP_EMIT_OK,  C_OUT_BUSY,   PC_EMIT,  PC_IDLE,  1'b0};
            PC_ERR:   w = '{OP_EMIT_ERR, C_OUT_BUSY,   PC_ERR,   PC_IDLE,  1'b0};
            default:  w = '{OP_NONE,     C_NONE,       PC_IDLE,  PC_IDLE,  1'b0};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w_word;
    logic            w_take;

    assign w_word = f_rom(r_pc);

    always_comb begin
        unique case (w_word.cond)
            C_NONE:       w_take = 1'b0;
            C_NO_COMPUTE: w_take = !i_stat.acc_compute;
            C_RANGE:      w_take = i_stat.range_err;
            C_EMPTY:      w_take = i_stat.empty;
            C_MORE:       w_take = i_stat.more;
            C_OUT_BUSY:   w_take = i_stat.out_busy;
            default:      w_take = 1'b0;
        endcase
        n_pc = w_take ? w_word.jump : w_word.nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_word;

endmodule

// ===== src/q15c_dp.sv =====
`timescale 1ns / 1ps
// q15c_dp: datapath; config registers, stores, shared multiplier, address
// walk, Q15 MAC pipeline and output register. Depends on q15c_pkg, q15c_ram.
module q15c_dp
    import q15c_pkg::*;
#(
    parameter int IMAGE_DEPTH  = IMAGE_DEPTH_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
    parameter int MAX_KERNELS  = MAX_KERNELS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl                  i_ctrl,
    output t_stat                  o_stat,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_valid,
    input  logic [OPC_W-1:0]       i_opcode,
    input  logic [STORE_IDX_W-1:0] i_store_index,
    input  logic [DATA_W-1:0]      i_load_value,
    input  logic [OC_W-1:0]        i_out_channel,
    input  logic [COORD_W-1:0]     i_out_row,
    input  logic [COORD_W-1:0]     i_out_col,
    output logic                   o_m_valid,
    input  logic                   i_m_ready,
    output logic [DATA_W-1:0]      o_conv_value,
    output logic                   o_range_error
);

    localparam int IMG_AW = (IMAGE_DEPTH > 1) ? $clog2(IMAGE_DEPTH) : 1;
    localparam int WGT_AW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int KW     = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;

    // configuration
    logic [ROWS_W-1:0] r_in_rows, r_in_cols;
    logic [CH_W-1:0]   r_in_ch, r_k_rows, r_k_cols;
    logic [KCNT_W-1:0] r_k_count;

    // latched request
    logic [OC_W-1:0]    r_oc;
    logic [COORD_W-1:0] r_orow, r_ocol;

    // setup results
    logic [PLANE_W-1:0] r_row, r_plane;
    logic [KSZ_W-1:0]   r_ksz;

    // address walk
    logic [IA_W-1:0] r_ia, r_rowb, r_chb;
    logic [WA_W-1:0] r_wa;
    logic [CH_W-1:0] r_c, r_r, r_k;

    // MAC pipeline
    logic              r_v1, r_v2, r_iok, r_wok;
    logic [DATA_W-1:0] r_prod, r_acc;

    logic [DATA_W-1:0] r_bias [MAX_KERNELS];

    logic              r_out_valid, r_out_err;
    logic [DATA_W-1:0] r_out_value;

    logic                w_acc;
    t_opcode             w_opc;
    logic                w_img_we, w_wgt_we, w_bias_we;
    logic [DATA_W-1:0]   w_img_q, w_wgt_q;
    logic [MA_W-1:0]     w_ma;
    logic [MB_W-1:0]     w_mb;
    logic [PROD_W-1:0]   w_prod;
    logic                w_k_last, w_r_last, w_c_last;
    logic [IA_W-1:0]     w_next_ch, w_next_row;
    logic [DATA_W-1:0]   w_img_op, w_wgt_op;
    logic [2*DATA_W-1:0] w_full;
    logic                w_range, w_out_busy, w_emit;

    assign w_acc = i_s_valid && i_ctrl.rdy;
    assign w_opc = t_opcode'(i_opcode);

    assign w_img_we  = w_acc && (w_opc == OPC_LOAD_IMG) && (32'(i_store_index) < IMAGE_DEPTH);
    assign w_wgt_we  = w_acc && (w_opc == OPC_LOAD_WGT) && (32'(i_store_index) < WEIGHT_DEPTH);
    assign w_bias_we = w_acc && (w_opc == OPC_LOAD_BIAS) && (32'(i_store_index) < MAX_KERNELS);

    q15c_ram #(.WIDTH(DATA_W), .DEPTH(IMAGE_DEPTH), .AW(IMG_AW)) u_img (
        .i_clk   (i_clk),
        .i_we    (w_img_we),
        .i_waddr (IMG_AW'(i_store_index)),
        .i_wdata (i_load_value),
        .i_raddr (IMG_AW'(r_ia)),
        .o_rdata (w_img_q)
    );

    q15c_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH), .AW(WGT_AW)) u_wgt (
        .i_clk   (i_clk),
        .i_we    (w_wgt_we),
        .i_waddr (WGT_AW'(i_store_index)),
        .i_wdata (i_load_value),
        .i_raddr (WGT_AW'(r_wa)),
        .o_rdata (w_wgt_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_bias_we) begin
            r_bias[KW'(i_store_index)] <= i_load_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rows <= 7'd28;
            r_in_cols <= 7'd28;
            r_in_ch   <= 4'd1;
            r_k_rows  <= 4'd3;
            r_k_cols  <= 4'd3;
            r_k_count <= 3'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IN_ROWS:      r_in_rows <= i_cfg_data;
                CFG_IN_COLS:      r_in_cols <= i_cfg_data;
                CFG_IN_CHANNELS:  r_in_ch   <= i_cfg_data[CH_W-1:0];
                CFG_KERNEL_ROWS:  r_k_rows  <= i_cfg_data[CH_W-1:0];
                CFG_KERNEL_COLS:  r_k_cols  <= i_cfg_data[CH_W-1:0];
                CFG_KERNEL_COUNT: r_k_count <= i_cfg_data[KCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // range check on the latched request
    assign w_range = (3'(r_oc) >= r_k_count) || (32'(r_oc) >= MAX_KERNELS)
        || ((8'(r_orow) + 8'(r_k_rows)) > 8'(r_in_rows))
        || ((8'(r_ocol) + 8'(r_k_cols)) > 8'(r_in_cols));

    // shared multiplier operands
    always_comb begin
        unique case (i_ctrl.op)
            OP_ROW: begin
                w_ma = MA_W'(r_orow);
                w_mb = r_in_cols;
            end
            OP_PLANE: begin
                w_ma = MA_W'(r_in_rows);
                w_mb = r_in_cols;
            end
            OP_KSZ0: begin
                w_ma = MA_W'(r_in_ch);
                w_mb = MB_W'(r_k_rows);
            end
            OP_KSZ1: begin
                w_ma = r_ksz;
                w_mb = MB_W'(r_k_cols);
            end
            OP_KBASE: begin
                w_ma = r_ksz;
                w_mb = MB_W'(r_oc);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_ma) * PROD_W'(w_mb);

    assign w_k_last   = (r_k + 4'd1) == r_k_cols;
    assign w_r_last   = (r_r + 4'd1) == r_k_rows;
    assign w_c_last   = (r_c + 4'd1) == r_in_ch;
    assign w_next_ch  = r_chb + IA_W'(r_plane);
    assign w_next_row = r_rowb + IA_W'(r_in_cols);

    always_ff @(posedge i_clk) begin
        if (w_acc && (w_opc == OPC_COMPUTE)) begin
            r_oc   <= i_out_channel;
            r_orow <= i_out_row;
            r_ocol <= i_out_col;
        end
        unique case (i_ctrl.op)
            OP_ROW:   r_row   <= PLANE_W'(w_prod) + PLANE_W'(r_ocol);
            OP_PLANE: r_plane <= PLANE_W'(w_prod);
            OP_KSZ0:  r_ksz   <= KSZ_W'(w_prod);
            OP_KSZ1:  r_ksz   <= KSZ_W'(w_prod);
            OP_KBASE: r_wa    <= WA_W'(w_prod);
            OP_INIT: begin
                r_ia   <= IA_W'(r_row);
                r_rowb <= IA_W'(r_row);
                r_chb  <= IA_W'(r_row);
                r_c    <= '0;
                r_r    <= '0;
                r_k    <= '0;
            end
            OP_MAC: begin
                r_wa <= r_wa + WA_W'(1);
                if (w_k_last) begin
                    r_k <= '0;
                    if (w_r_last) begin
                        r_r    <= '0;
                        r_c    <= r_c + 4'd1;
                        r_chb  <= w_next_ch;
                        r_rowb <= w_next_ch;
                        r_ia   <= w_next_ch;
                    end else begin
                        r_r    <= r_r + 4'd1;
                        r_rowb <= w_next_row;
                        r_ia   <= w_next_row;
                    end
                end else begin
                    r_k  <= r_k + 4'd1;
                    r_ia <= r_ia + IA_W'(1);
                end
            end
            default: ;
        endcase
    end

    // MAC pipeline: read, multiply, accumulate
    assign w_img_op = r_iok ? w_img_q : '0;
    assign w_wgt_op = r_wok ? w_wgt_q : '0;
    assign w_full   = $signed(w_img_op) * $signed(w_wgt_op);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= (i_ctrl.op == OP_MAC);
            r_v2 <= r_v1;
        end
        r_iok  <= 32'(r_ia) < IMAGE_DEPTH;
        r_wok  <= 32'(r_wa) < WEIGHT_DEPTH;
        r_prod <= w_full[QSHIFT +: DATA_W];
        if (i_ctrl.op == OP_INIT) begin
            r_acc <= r_bias[KW'(r_oc)];
        end else if (r_v2) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // output register
    assign w_out_busy = r_out_valid && !i_m_ready;
    assign w_emit = ((i_ctrl.op == OP_EMIT_OK) || (i_ctrl.op == OP_EMIT_ERR)) && !w_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_out_value <= (i_ctrl.op == OP_EMIT_OK) ? r_acc : '0;
            r_out_err   <= (i_ctrl.op == OP_EMIT_ERR);
        end
    end

    assign o_stat.acc_compute = w_acc && (w_opc == OPC_COMPUTE);
    assign o_stat.range_err   = w_range;
    assign o_stat.empty       = (r_in_ch == '0) || (r_k_rows == '0) || (r_k_cols == '0);
    assign o_stat.more        = !(w_k_last && w_r_last && w_c_last);
    assign o_stat.out_busy    = w_out_busy;

    assign o_m_valid     = r_out_valid;
    assign o_conv_value  = r_out_value;
    assign o_range_error = r_out_err;

endmodule

// ===== src/q15_conv3d_valid_core.sv =====
`timescale 1ns / 1ps
// q15_conv3d_valid_core: top level of the Q15 valid convolution engine.
// Depends on q15c_pkg, q15c_seq, q15c_dp (and q15c_ram through q15c_dp).
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tdata: requests, tuser: opcode
//  m_axis    out        tvalid / tready        tdata: conv_value, tuser: range_error
//  cfg       in         valid / ready (ready=1) index, data
//
// A load is written as it is accepted and leaves the core ready. A compute
// request runs the setup steps, then N = in_channels * kernel_rows * kernel_cols
// MACs, one per cycle on each store's single read port; a range error skips them.
// Reset clears control and restores the register defaults; stores are not cleared.
// A result waiting on m_axis does not block loads or the next compute; only
// the final step of a compute waits for the output register to free up.
module q15_conv3d_valid_core
    import q15c_pkg::*;
#(
    parameter int IMAGE_DEPTH  = IMAGE_DEPTH_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
    parameter int MAX_KERNELS  = MAX_KERNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // store_index, load_value, out_channel, out_row, out_col, zero pad
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode
    input  logic [OPC_W-1:0]      i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // conv_value
    output logic [DATA_W-1:0]     o_m_axis_tdata,
    // range_error
    output logic                  o_m_axis_tuser
);

    localparam int VAL_LO = STORE_IDX_W;
    localparam int OC_LO  = VAL_LO + DATA_W;
    localparam int ROW_LO = OC_LO + OC_W;
    localparam int COL_LO = ROW_LO + COORD_W;

    t_ctrl w_ctrl;
    t_stat w_stat;

    q15c_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    q15c_dp #(
        .IMAGE_DEPTH  (IMAGE_DEPTH),
        .WEIGHT_DEPTH (WEIGHT_DEPTH),
        .MAX_KERNELS  (MAX_KERNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_s_valid     (i_s_axis_tvalid),
        .i_opcode      (i_s_axis_tuser),
        .i_store_index (i_s_axis_tdata[STORE_IDX_W-1:0]),
        .i_load_value  (i_s_axis_tdata[VAL_LO +: DATA_W]),
        .i_out_channel (i_s_axis_tdata[OC_LO +: OC_W]),
        .i_out_row     (i_s_axis_tdata[ROW_LO +: COORD_W]),
        .i_out_col     (i_s_axis_tdata[COL_LO +: COORD_W]),
        .o_m_valid     (o_m_axis_tvalid),
        .i_m_ready     (i_m_axis_tready),
        .o_conv_value  (o_m_axis_tdata),
        .o_range_error (o_m_axis_tuser)
    );

    assign o_s_axis_tready = w_ctrl.rdy;
    assign o_cfg_ready     = 1'b1;

endmodule

// ===== sim/q15_conv3d_result_chk.sv =====
`timescale 1ns / 1ps
// q15_conv3d_result_chk: watches the config, request and result channels of the Q15
// convolution core, predicts every result and compares it. Depends on q15c_pkg.
module q15_conv3d_result_chk
    import q15c_pkg::*;
#(
    parameter int IMAGE_DEPTH  = IMAGE_DEPTH_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
    parameter int MAX_KERNELS  = MAX_KERNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic [OPC_W-1:0]      i_s_axis_tuser,
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [DATA_W-1:0]     i_m_axis_tdata,
    input  logic                  i_m_axis_tuser,
    output int unsigned           o_pending,
    output int unsigned           o_errors
);

    localparam int VAL_LSB = STORE_IDX_W;
    localparam int OC_LSB  = VAL_LSB + DATA_W;
    localparam int ROW_LSB = OC_LSB + OC_W;
    localparam int COL_LSB = ROW_LSB + COORD_W;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              range_err;
    } conv_result_t;

    logic [DATA_W-1:0] image_mem  [IMAGE_DEPTH];
    logic [DATA_W-1:0] weight_mem [WEIGHT_DEPTH];
    logic [DATA_W-1:0] bias_mem   [MAX_KERNELS];

    int unsigned rows_q, cols_q, chans_q, krows_q, kcols_q, kcount_q;

    conv_result_t results_due[$];
    conv_result_t due;
    int unsigned  fail_count = 0;
    int unsigned  req_idx;

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    // bias plus wrapped sum of Q15 products over the window
    function automatic conv_result_t conv_point(int unsigned oc, int unsigned row,
                                                int unsigned col);
        int unsigned       plane, ksize, ia, wa;
        logic [DATA_W-1:0] acc, px, wt;
        logic signed [31:0] prod;
        conv_result_t      res;
        res.value     = '0;
        res.range_err = 1'b1;
        if (oc >= kcount_q || oc >= MAX_KERNELS || row + krows_q > rows_q ||
            col + kcols_q > cols_q)
            return res;
        plane = rows_q * cols_q;
        ksize = chans_q * krows_q * kcols_q;
        acc   = bias_mem[oc];
        for (int unsigned c = 0; c < chans_q; c++) begin
            for (int unsigned r = 0; r < krows_q; r++) begin
                for (int unsigned k = 0; k < kcols_q; k++) begin
                    ia   = c * plane + (row + r) * cols_q + col + k;
                    wa   = oc * ksize + (c * krows_q + r) * kcols_q + k;
                    px   = (ia < IMAGE_DEPTH) ? image_mem[ia] : '0;
                    wt   = (wa < WEIGHT_DEPTH) ? weight_mem[wa] : '0;
                    prod = $signed(px) * $signed(wt);
                    acc  = acc + prod[QSHIFT +: DATA_W];
                end
            end
        end
        res.value     = acc;
        res.range_err = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_q   = 28;
            cols_q   = 28;
            chans_q  = 1;
            krows_q  = 3;
            kcols_q  = 3;
            kcount_q = 2;
            results_due.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $error("result with none due: conv_value %h range_error %b",
                           i_m_axis_tdata, i_m_axis_tuser);
                    fail_count++;
                end else begin
                    due = results_due.pop_front();
                    if (i_m_axis_tdata !== due.value) begin
                        $error("conv_value: expected %0d, got %0d",
                               $signed(due.value), $signed(i_m_axis_tdata));
                        fail_count++;
                    end
                    if (i_m_axis_tuser !== due.range_err) begin
                        $error("range_error: expected %b, got %b",
                               due.range_err, i_m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IN_ROWS:      rows_q   = i_cfg_data[ROWS_W-1:0];
                    CFG_IN_COLS:      cols_q   = i_cfg_data[ROWS_W-1:0];
                    CFG_IN_CHANNELS:  chans_q  = i_cfg_data[CH_W-1:0];
                    CFG_KERNEL_ROWS:  krows_q  = i_cfg_data[CH_W-1:0];
                    CFG_KERNEL_COLS:  kcols_q  = i_cfg_data[CH_W-1:0];
                    CFG_KERNEL_COUNT: kcount_q = i_cfg_data[KCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                req_idx = i_s_axis_tdata[STORE_IDX_W-1:0];
                case (i_s_axis_tuser)
                    OPC_LOAD_IMG:
                        if (req_idx < IMAGE_DEPTH)
                            image_mem[req_idx] = i_s_axis_tdata[VAL_LSB +: DATA_W];
                    OPC_LOAD_WGT:
                        if (req_idx < WEIGHT_DEPTH)
                            weight_mem[req_idx] = i_s_axis_tdata[VAL_LSB +: DATA_W];
                    OPC_LOAD_BIAS:
                        if (req_idx < MAX_KERNELS)
                            bias_mem[req_idx] = i_s_axis_tdata[VAL_LSB +: DATA_W];
                    default:
                        results_due.push_back(conv_point(i_s_axis_tdata[OC_LSB +: OC_W],
                                                         i_s_axis_tdata[ROW_LSB +: COORD_W],
                                                         i_s_axis_tdata[COL_LSB +: COORD_W]));
                endcase
            end
        end
        o_pending <= results_due.size();
        o_errors  <= fail_count;
    end

endmodule

// ===== sim/q15_conv3d_valid_core_tb.sv =====
`timescale 1ns / 1ps
// q15_conv3d_valid_core_tb: drives loads, computes and register writes into the Q15
// convolution core and gives the verdict. Depends on q15c_pkg, the core and q15_conv3d_result_chk.
module q15_conv3d_valid_core_tb;
    import q15c_pkg::*;

    localparam int     CLK_HALF_NS   = 4;
    localparam int     RESET_CYCLES  = 11;
    localparam int     ITEM_TARGET   = 1950;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     SETTLE_CYCLES = 24;
    localparam longint TIMEOUT_NS    = 40_000_000;
    localparam int     IDX_MAX       = (1 << STORE_IDX_W) - 1;
    localparam int     COORD_MAX     = (1 << COORD_W) - 1;
    localparam int     OC_MAX        = (1 << OC_W) - 1;
    localparam int     ROWS_MAX      = (1 << ROWS_W) - 1;
    localparam int     CH_MAX        = (1 << CH_W) - 1;
    localparam int     KCNT_MAX      = (1 << KCNT_W) - 1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OPC_W-1:0]      s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_ready, s_tready, m_tvalid, m_tuser;
    logic [DATA_W-1:0]     m_tdata;
    int unsigned           pending, errors;

    // shadow of the register file and of which store entries hold data
    int unsigned rows_cfg = 28, cols_cfg = 28, chans_cfg = 1;
    int unsigned krows_cfg = 3, kcols_cfg = 3, kcount_cfg = 2;
    bit          image_set  [IMAGE_DEPTH_DEF];
    bit          weight_set [WEIGHT_DEPTH_DEF];
    bit          bias_set   [MAX_KERNELS_DEF];

    int unsigned items_sent = 0;
    int unsigned hold_asks  = 0;
    bit          burst      = 1'b0;

    always #(CLK_HALF_NS) clk = ~clk;

    q15_conv3d_valid_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    q15_conv3d_result_chk u_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_q15();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0001;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_dim(int unsigned lo, int unsigned hi,
                                             int unsigned full);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, full) : $urandom_range(lo, hi);
    endfunction

    function automatic bit window_ok(int unsigned oc, int unsigned row, int unsigned col);
        return oc < kcount_cfg && oc < MAX_KERNELS_DEF && row + krows_cfg <= rows_cfg &&
               col + kcols_cfg <= cols_cfg;
    endfunction

    task automatic send_req(t_opcode opc, logic [STORE_IDX_W-1:0] idx,
                            logic [DATA_W-1:0] val, logic [OC_W-1:0] oc,
                            logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opc;
        s_tdata  <= S_TDATA_W'({col, row, oc, val, idx});
        do @(posedge clk); while (!s_tready);
        case (opc)
            OPC_LOAD_IMG: begin
                image_set[idx] = 1'b1;
                items_sent++;
            end
            OPC_LOAD_WGT:
                if (idx < WEIGHT_DEPTH_DEF) begin
                    weight_set[idx] = 1'b1;
                    items_sent++;
                end
            OPC_LOAD_BIAS:
                if (idx < MAX_KERNELS_DEF) begin
                    bias_set[idx] = 1'b1;
                    items_sent++;
                end
            default: items_sent++;
        endcase
    endtask

    task automatic load(t_opcode opc, int unsigned idx, logic [DATA_W-1:0] val);
        send_req(opc, STORE_IDX_W'(idx), val, OC_W'($urandom), COORD_W'($urandom),
                 COORD_W'($urandom));
    endtask

    task automatic compute(int unsigned oc, int unsigned row, int unsigned col);
        send_req(OPC_COMPUTE, STORE_IDX_W'($urandom), DATA_W'($urandom), OC_W'(oc),
                 COORD_W'(row), COORD_W'(col));
    endtask

    // load every entry the window will read that holds no data yet, then send the compute
    task automatic compute_filled(int unsigned oc, int unsigned row, int unsigned col);
        int unsigned plane, ksize, ia, wa;
        if (window_ok(oc, row, col)) begin
            plane = rows_cfg * cols_cfg;
            ksize = chans_cfg * krows_cfg * kcols_cfg;
            for (int unsigned c = 0; c < chans_cfg; c++) begin
                for (int unsigned r = 0; r < krows_cfg; r++) begin
                    for (int unsigned k = 0; k < kcols_cfg; k++) begin
                        ia = c * plane + (row + r) * cols_cfg + col + k;
                        wa = oc * ksize + (c * krows_cfg + r) * kcols_cfg + k;
                        if (ia < IMAGE_DEPTH_DEF && !image_set[ia])
                            load(OPC_LOAD_IMG, ia, pick_q15());
                        if (wa < WEIGHT_DEPTH_DEF && !weight_set[wa])
                            load(OPC_LOAD_WGT, wa, pick_q15());
                    end
                end
            end
            if (!bias_set[oc])
                load(OPC_LOAD_BIAS, oc, pick_q15());
        end
        compute(oc, row, col);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // loads leave no result behind, so drain the results, then let the core idle for SETTLE_CYCLES
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_IN_ROWS:      rows_cfg   = data[ROWS_W-1:0];
            CFG_IN_COLS:      cols_cfg   = data[ROWS_W-1:0];
            CFG_IN_CHANNELS:  chans_cfg  = data[CH_W-1:0];
            CFG_KERNEL_ROWS:  krows_cfg  = data[CH_W-1:0];
            CFG_KERNEL_COLS:  kcols_cfg  = data[CH_W-1:0];
            CFG_KERNEL_COUNT: kcount_cfg = data[KCNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned rows, int unsigned cols, int unsigned chans,
                              int unsigned kr, int unsigned kc, int unsigned kcnt);
        settle();
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_KERNEL_COUNT + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        write_reg(CFG_IN_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_IN_COLS, CFG_DATA_W'(cols));
        write_reg(CFG_IN_CHANNELS, CFG_DATA_W'(chans));
        write_reg(CFG_KERNEL_ROWS, CFG_DATA_W'(kr));
        write_reg(CFG_KERNEL_COLS, CFG_DATA_W'(kc));
        write_reg(CFG_KERNEL_COUNT, CFG_DATA_W'(kcnt));
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_window(output int unsigned oc, output int unsigned row,
                               output int unsigned col, output bit ok);
        int unsigned kmax;
        kmax = (kcount_cfg < MAX_KERNELS_DEF) ? kcount_cfg : MAX_KERNELS_DEF;
        ok   = kmax > 0 && krows_cfg <= rows_cfg && kcols_cfg <= cols_cfg;
        oc   = 0;
        row  = 0;
        col  = 0;
        if (ok) begin
            oc  = $urandom_range(0, kmax - 1);
            row = $urandom_range(0, (rows_cfg - krows_cfg < COORD_MAX) ?
                                    rows_cfg - krows_cfg : COORD_MAX);
            col = $urandom_range(0, (cols_cfg - kcols_cfg < COORD_MAX) ?
                                    cols_cfg - kcols_cfg : COORD_MAX);
        end
    endtask

    task automatic run_phase(int unsigned n, bit squeeze);
        int unsigned oc, row, col, kind;
        bit          ok;
        burst = squeeze;
        if (squeeze)
            hold_asks++;
        for (int unsigned i = 0; i < n; i++) begin
            if (i == n / 2)
                drain_results();
            if (i % 40 == 39)
                burst = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                pick_window(oc, row, col, ok);
                if (ok)
                    compute_filled(oc, row, col);
                else
                    compute($urandom_range(0, OC_MAX), $urandom_range(0, COORD_MAX),
                            $urandom_range(0, COORD_MAX));
            end else if (kind < 60) begin
                compute_filled($urandom_range(0, OC_MAX), $urandom_range(0, COORD_MAX),
                               $urandom_range(0, COORD_MAX));
            end else if (kind < 75) begin
                load(OPC_LOAD_IMG, $urandom_range(0, IDX_MAX), pick_q15());
            end else if (kind < 88) begin
                load(OPC_LOAD_WGT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, IDX_MAX) :
                     $urandom_range(0, WEIGHT_DEPTH_DEF - 1), pick_q15());
            end else if (kind < 95) begin
                load(OPC_LOAD_BIAS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDX_MAX) :
                     $urandom_range(0, MAX_KERNELS_DEF - 1), pick_q15());
            end else begin
                load(t_opcode'($urandom_range(OPC_LOAD_IMG, OPC_LOAD_BIAS)),
                     $urandom_range(0, IDX_MAX), DATA_W'($urandom));
            end
        end
        burst = 1'b0;
    endtask

    // 2x2 single-channel image, 1x1 kernels: product extremes, wrap, range errors,
    // loads past the end of the weight and bias stores and into the last image entry
    task automatic directed();
        set_config(2, 2, 1, 1, 1, 2);
        load(OPC_LOAD_IMG, 0, 16'h8000);
        load(OPC_LOAD_WGT, 0, 16'h8000);
        load(OPC_LOAD_BIAS, 0, 16'h7FFF);
        compute(0, 0, 0);
        load(OPC_LOAD_IMG, 0, 16'h7FFF);
        load(OPC_LOAD_WGT, 0, 16'h7FFF);
        compute(0, 0, 0);
        load(OPC_LOAD_IMG, 3, 16'hFFFF);
        load(OPC_LOAD_WGT, 1, 16'h0001);
        load(OPC_LOAD_BIAS, 1, 16'h8000);
        compute(1, 1, 1);
        compute(2, 0, 0);
        compute(OC_MAX, COORD_MAX, COORD_MAX);
        compute(0, 2, 0);
        compute(0, 0, 2);
        load(OPC_LOAD_WGT, WEIGHT_DEPTH_DEF, 16'h1234);
        load(OPC_LOAD_WGT, IDX_MAX, 16'h5A5A);
        load(OPC_LOAD_BIAS, MAX_KERNELS_DEF, 16'h4321);
        load(OPC_LOAD_BIAS, IDX_MAX, 16'hA5A5);
        load(OPC_LOAD_IMG, IDX_MAX, 16'h7FFF);
        compute(0, 0, 0);
        compute(1, 1, 1);
    endtask

    // result side: random stalls, steady stretches, and a long hold-off on request
    initial begin
        int unsigned seen, stall, mode_left;
        bit          steady;
        seen      = 0;
        stall     = 0;
        mode_left = 0;
        steady    = 1'b0;
        forever begin
            @(posedge clk);
            if (seen != hold_asks) begin
                seen = hold_asks;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0) begin
                mode_left = 200;
                steady    = ($urandom_range(0, 3) == 0);
            end
            mode_left--;
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (steady || $urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                                                      $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("q15_conv3d_valid_core_tb: errors");
        $finish;
    end

    initial begin
        int unsigned phase;
        phase = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_phase(40, 1'b0);
        directed();
        set_config(64, 64, 8, 8, 8, 4);
        run_phase(8, 1'b0);
        set_config(ROWS_MAX, ROWS_MAX, (1 << CFG_DATA_W) - 1, (1 << CFG_DATA_W) - 1,
                   (1 << CFG_DATA_W) - 1, (1 << CFG_DATA_W) - 1);
        run_phase(6, 1'b0);
        set_config(0, 0, 0, 0, 0, 0);
        run_phase(10, 1'b0);
        set_config(0, 0, 5, 0, 0, 4);
        run_phase(10, 1'b0);
        set_config(1, 1, 1, 1, 1, 1);
        run_phase(20, 1'b0);
        while (items_sent < ITEM_TARGET) begin
            set_config(pick_dim(1, 10, ROWS_MAX), pick_dim(1, 10, ROWS_MAX),
                       pick_dim(1, 3, CH_MAX), pick_dim(1, 4, CH_MAX),
                       pick_dim(1, 4, CH_MAX), pick_dim(1, 4, KCNT_MAX));
            run_phase(120, phase % 4 == 0);
            phase++;
        end
        settle();
        if (errors == 0 && pending == 0)
            $display("q15_conv3d_valid_core_tb: clean");
        else
            $display("q15_conv3d_valid_core_tb: errors");
        $finish;
    end

endmodule

// ===== q15_conv3d_valid_core.f =====
src/q15c_pkg.sv
src/q15c_ram.sv
src/q15c_seq.sv
src/q15c_dp.sv
src/q15_conv3d_valid_core.sv
sim/q15_conv3d_result_chk.sv
sim/q15_conv3d_valid_core_tb.sv
